### design/pefm_pkg.sv
package pefm_pkg;

    localparam int NC = 4;
    localparam int NP = 2 * NC - 1;
    localparam int MUL_LAT = 5;

    localparam logic [29:0] P = 30'd998244353;
    // barrett constant floor(2^60 / p)
    localparam logic [30:0] MU = 31'(64'd1152921504606846976 / 64'd998244353);

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MUL = 1'b1;

    localparam logic [2:0] CFG_DEGREE = 3'd0;
    localparam logic [2:0] CFG_COEF_0 = 3'd1;
    localparam logic [2:0] CFG_COEF_1 = 3'd2;
    localparam logic [2:0] CFG_COEF_2 = 3'd3;
    localparam logic [2:0] CFG_COEF_3 = 3'd4;

    typedef logic [29:0] t_coef;
    typedef logic [2:0]  t_deg;

    typedef struct packed {
        logic valid;
        logic op;
    } t_ctl;

    typedef struct packed {
        t_deg             n;
        t_coef [NC-1:0]   c;
    } t_cfg;

    function automatic t_coef to_field(input t_coef v);
        return (v >= P) ? t_coef'(v - P) : v;
    endfunction

    function automatic t_coef add_p(input t_coef a, input t_coef b);
        logic [30:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, P}) ? t_coef'(s - {1'b0, P}) : s[29:0];
    endfunction

    function automatic t_coef sub_p(input t_coef a, input t_coef b);
        logic [30:0] s;
        s = {1'b0, a} + {1'b0, P} - {1'b0, b};
        return (a >= b) ? t_coef'(a - b) : s[29:0];
    endfunction

endpackage

### design/pefm_mulmod.sv
module pefm_mulmod (
    input  logic             i_clk,
    input  pefm_pkg::t_coef  i_a,
    input  pefm_pkg::t_coef  i_b,
    output pefm_pkg::t_coef  o_p
);
    import pefm_pkg::*;

    localparam logic [31:0] P32 = 32'(P);
    localparam logic [31:0] P2  = 32'(2 * P32);

    logic [59:0] r_prod;
    logic [61:0] r_qe;
    logic [59:0] r_x2;
    logic [31:0] r_qp;
    logic [31:0] r_x3;
    logic [31:0] r_rem;
    t_coef       r_res;
    logic [29:0] n_q;
    t_coef       n_res;

    // quotient estimate, at most two short of the true one
    assign n_q = r_qe[60:31];

    always_comb begin
        if (r_rem >= P2) begin
            n_res = t_coef'(r_rem - P2);
        end else if (r_rem >= P32) begin
            n_res = t_coef'(r_rem - P32);
        end else begin
            n_res = r_rem[29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 60'(i_a) * 60'(i_b);
        r_qe   <= 62'(r_prod[59:29]) * 62'(MU);
        r_x2   <= r_prod;
        r_qp   <= 32'(n_q) * P32;
        r_x3   <= r_x2[31:0];
        r_rem  <= r_x3 - r_qp;
        r_res  <= n_res;
    end

    assign o_p = r_res;

endmodule

### design/pefm_product.sv
module pefm_product (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pefm_pkg::t_ctl   i_ctl,
    input  pefm_pkg::t_coef  i_a [pefm_pkg::NC],
    input  pefm_pkg::t_coef  i_b [pefm_pkg::NC],
    output pefm_pkg::t_ctl   o_ctl,
    output pefm_pkg::t_coef  o_r [pefm_pkg::NP]
);
    import pefm_pkg::*;

    localparam int DL = MUL_LAT + 2;

    t_coef w_prod [NC][NC];
    t_coef r_a    [MUL_LAT][NC];
    t_coef r_b    [MUL_LAT][NC];
    t_ctl  r_ctl  [DL];
    t_coef r_s1   [NP][2];
    t_coef n_s1   [NP][2];
    t_coef r_out  [NP];

    for (genvar gi = 0; gi < NC; gi++) begin : g_row
        for (genvar gj = 0; gj < NC; gj++) begin : g_col
            pefm_mulmod u_mul (
                .i_clk (i_clk),
                .i_a   (i_a[gi]),
                .i_b   (i_b[gj]),
                .o_p   (w_prod[gi][gj])
            );
        end
    end

    // first add level: even and odd rows of each diagonal, or the coefficient sum in add mode
    always_comb begin
        int j0;
        int j1;
        t_coef x0;
        t_coef x1;
        for (int k = 0; k < NP; k++) begin
            for (int h = 0; h < 2; h++) begin
                j0 = k - h;
                j1 = k - h - 2;
                x0 = '0;
                x1 = '0;
                if (j0 >= 0 && j0 < NC) begin
                    x0 = w_prod[h][j0];
                end
                if (j1 >= 0 && j1 < NC && h + 2 < NC) begin
                    x1 = w_prod[h + 2][j1];
                end
                n_s1[k][h] = add_p(x0, x1);
            end
            if (r_ctl[MUL_LAT-1].op == OP_ADD) begin
                n_s1[k][0] = (k < NC) ? add_p(r_a[MUL_LAT-1][k], r_b[MUL_LAT-1][k]) : '0;
                n_s1[k][1] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a[0] <= i_a;
        r_b[0] <= i_b;
        for (int s = 1; s < MUL_LAT; s++) begin
            r_a[s] <= r_a[s-1];
            r_b[s] <= r_b[s-1];
        end
        r_s1 <= n_s1;
        for (int k = 0; k < NP; k++) begin
            r_out[k] <= add_p(r_s1[k][0], r_s1[k][1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DL; s++) begin
                r_ctl[s] <= '0;
            end
        end else begin
            r_ctl[0] <= i_ctl;
            for (int s = 1; s < DL; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    assign o_ctl = r_ctl[DL-1];
    assign o_r   = r_out;

endmodule

### design/pefm_reduce_step.sv
module pefm_reduce_step #(
    parameter int K = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pefm_pkg::t_ctl   i_ctl,
    input  pefm_pkg::t_cfg   i_cfg,
    input  pefm_pkg::t_coef  i_r [pefm_pkg::NP],
    output pefm_pkg::t_ctl   o_ctl,
    output pefm_pkg::t_coef  o_r [pefm_pkg::NP]
);
    import pefm_pkg::*;

    t_coef w_prod [NC];
    t_coef r_dl   [MUL_LAT][NP];
    t_ctl  r_ctl  [MUL_LAT];
    t_ctl  r_octl;
    t_coef r_out  [NP];
    t_coef n_out  [NP];
    logic  w_act;

    // top term times each reduction coefficient
    for (genvar gi = 0; gi < NC; gi++) begin : g_mul
        pefm_mulmod u_mul (
            .i_clk (i_clk),
            .i_a   (i_r[K]),
            .i_b   (i_cfg.c[gi]),
            .o_p   (w_prod[gi])
        );
    end

    assign w_act = (r_ctl[MUL_LAT-1].op == OP_MUL) && (int'(i_cfg.n) <= K)
                   && (K <= 2 * int'(i_cfg.n) - 2);

    // x^K folds into x^(K-n) .. x^(K-1)
    always_comb begin
        int nn;
        nn = int'(i_cfg.n);
        for (int j = 0; j < NP; j++) begin
            n_out[j] = r_dl[MUL_LAT-1][j];
            if (w_act) begin
                if (j == K) begin
                    n_out[j] = '0;
                end
                for (int i = 0; i < NC; i++) begin
                    if (i < nn && j == K - nn + i) begin
                        n_out[j] = sub_p(r_dl[MUL_LAT-1][j], w_prod[i]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl[0] <= i_r;
        for (int s = 1; s < MUL_LAT; s++) begin
            r_dl[s] <= r_dl[s-1];
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MUL_LAT; s++) begin
                r_ctl[s] <= '0;
            end
            r_octl <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
            for (int s = 1; s < MUL_LAT; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
            r_octl <= r_ctl[MUL_LAT-1];
        end
    end

    assign o_ctl = r_octl;
    assign o_r   = r_out;

endmodule

### design/prime_extension_field_mul_add_top.sv
// add / multiply in GF(p^n), p = 998244353, polynomial basis, n set by the degree
// register (saturated into 1..MAX_DEGREE), reduction by the monic polynomial with
// implicit leading one. fully pipelined: one word may be started every cycle
// (busy is always low). the result word is strobed on o_valid after one input
// register, seven in the product stage (five-stage modular multiplier plus two add
// levels), five serial reduction steps of six each (multiplier plus subtract), and
// one output register. results are shown for one cycle only; the receiver cannot
// stall, so it must take every strobed word. configuration is to be written by the
// user only while no word is in flight; the block itself does not enforce it.
module prime_extension_field_mul_add_top #(
    parameter int MAX_DEGREE = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command side
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [29:0] i_a_coef_0,
    input  logic [29:0] i_a_coef_1,
    input  logic [29:0] i_a_coef_2,
    input  logic [29:0] i_a_coef_3,
    input  logic [29:0] i_b_coef_0,
    input  logic [29:0] i_b_coef_1,
    input  logic [29:0] i_b_coef_2,
    input  logic [29:0] i_b_coef_3,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [29:0] i_cfg_data,
    // result side
    output logic        o_valid,
    output logic [29:0] o_r_coef_0,
    output logic [29:0] o_r_coef_1,
    output logic [29:0] o_r_coef_2,
    output logic [29:0] o_r_coef_3
);
    import pefm_pkg::*;

    localparam int NS  = NP - 2;
    localparam int LAT = 1 + (MUL_LAT + 2) + NS * (MUL_LAT + 1) + 1;

    // configuration registers
    t_deg  r_deg;
    t_coef r_rc [NC];
    t_cfg  n_cfg;
    t_cfg  r_cfg;

    // input stage
    t_ctl  r_ctl0;
    t_coef r_a [NC];
    t_coef r_b [NC];
    t_coef w_ain [NC];
    t_coef w_bin [NC];

    // pipeline links
    t_coef w_r   [NS+1][NP];
    t_ctl  w_ctl [NS+1];

    // output stage
    logic  r_valid;
    t_coef r_res [NC];

    // never stalls
    assign busy = 1'b0;

    assign w_ain = '{i_a_coef_0, i_a_coef_1, i_a_coef_2, i_a_coef_3};
    assign w_bin = '{i_b_coef_0, i_b_coef_1, i_b_coef_2, i_b_coef_3};

    // saturated degree and reduced coefficients, zero at and above n
    always_comb begin
        if (r_deg == '0) begin
            n_cfg.n = t_deg'(1);
        end else if (int'(r_deg) > MAX_DEGREE) begin
            n_cfg.n = t_deg'(MAX_DEGREE);
        end else begin
            n_cfg.n = r_deg;
        end
        for (int i = 0; i < NC; i++) begin
            n_cfg.c[i] = (i < int'(n_cfg.n)) ? to_field(r_rc[i]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg   <= t_deg'(2);
            r_rc[0] <= t_coef'(1);
            r_rc[1] <= t_coef'(1);
            r_rc[2] <= '0;
            r_rc[3] <= '0;
            r_cfg.n <= t_deg'(2);
            r_cfg.c <= {t_coef'(0), t_coef'(0), t_coef'(1), t_coef'(1)};
        end else begin
            r_cfg <= n_cfg;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DEGREE: r_deg   <= i_cfg_data[2:0];
                    CFG_COEF_0: r_rc[0] <= i_cfg_data;
                    CFG_COEF_1: r_rc[1] <= i_cfg_data;
                    CFG_COEF_2: r_rc[2] <= i_cfg_data;
                    CFG_COEF_3: r_rc[3] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // input stage: reduce into the field, drop coefficients at and above n
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NC; i++) begin
            r_a[i] <= (i < int'(n_cfg.n)) ? to_field(w_ain[i]) : '0;
            r_b[i] <= (i < int'(n_cfg.n)) ? to_field(w_bin[i]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else begin
            r_ctl0.valid <= start && !busy;
            r_ctl0.op    <= i_opcode;
        end
    end

    // schoolbook product or coefficient sum
    pefm_product u_product (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl0),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_ctl   (w_ctl[0]),
        .o_r     (w_r[0])
    );

    // reduction, highest power first
    for (genvar gs = 0; gs < NS; gs++) begin : g_red
        pefm_reduce_step #(
            .K (NP - 1 - gs)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[gs]),
            .i_cfg   (r_cfg),
            .i_r     (w_r[gs]),
            .o_ctl   (w_ctl[gs+1]),
            .o_r     (w_r[gs+1])
        );
    end

    // output register, coefficients at and above n forced to zero
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NC; i++) begin
            r_res[i] <= (i < int'(r_cfg.n)) ? w_r[NS][i] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_ctl[NS].valid;
        end
    end

    assign o_valid    = r_valid;
    assign o_r_coef_0 = r_res[0];
    assign o_r_coef_1 = r_res[1];
    assign o_r_coef_2 = r_res[2];
    assign o_r_coef_3 = r_res[3];

    // every started word comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_valid)
        else $error("result word missing after pipeline latency");

    // results are fully reduced
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_r_coef_0 < P) && (o_r_coef_1 < P) && (o_r_coef_2 < P)
                    && (o_r_coef_3 < P))
        else $error("result coefficient not reduced mod p");

    // coefficients above the degree stay zero
    a_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_cfg.n > t_deg'(3) || o_r_coef_3 == '0)
                    && (r_cfg.n > t_deg'(2) || o_r_coef_2 == '0))
        else $error("nonzero coefficient above extension degree");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pefm_pkg::*;

    localparam longint unsigned FIELD = 64'd998244353;
    localparam int RESULT_LAT = 39;
    localparam int CYCLE_LIMIT = 400000;

    // one input word: opcode plus both operands
    typedef struct {
        logic         op;
        t_coef [3:0]  a;
        t_coef [3:0]  b;
    } t_word;

    typedef t_coef [3:0] t_elem;

    logic        i_clk;
    logic        i_rst_n;
    logic        start = 1'b0;
    logic        busy;
    logic        i_opcode;
    logic [29:0] i_a_coef_0, i_a_coef_1, i_a_coef_2, i_a_coef_3;
    logic [29:0] i_b_coef_0, i_b_coef_1, i_b_coef_2, i_b_coef_3;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [29:0] i_cfg_data;
    logic        o_valid;
    logic [29:0] o_r_coef_0, o_r_coef_1, o_r_coef_2, o_r_coef_3;

    prime_extension_field_mul_add_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_a_coef_0 (i_a_coef_0),
        .i_a_coef_1 (i_a_coef_1),
        .i_a_coef_2 (i_a_coef_2),
        .i_a_coef_3 (i_a_coef_3),
        .i_b_coef_0 (i_b_coef_0),
        .i_b_coef_1 (i_b_coef_1),
        .i_b_coef_2 (i_b_coef_2),
        .i_b_coef_3 (i_b_coef_3),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_r_coef_0 (o_r_coef_0),
        .o_r_coef_1 (o_r_coef_1),
        .o_r_coef_2 (o_r_coef_2),
        .o_r_coef_3 (o_r_coef_3)
    );

    // words waiting to be driven and field results waiting to come out
    t_word pending_words[$];
    t_elem expected_elems[$];

    // shadow of the configuration registers
    logic [2:0]  shadow_deg;
    t_coef [3:0] shadow_poly;

    int issued_cnt = 0;
    int accepted_cnt = 0;
    int idle_left = 0;
    bit quiet;
    int err_cnt = 0;
    int cycle_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // bring a 30-bit value into 0..p-1 with one subtraction
    function automatic longint unsigned fold(input t_coef v);
        longint unsigned x;
        x = 64'(v);
        return (x >= FIELD) ? x - FIELD : x;
    endfunction

    // add or multiply two elements under the shadow configuration
    function automatic t_elem field_op(input t_word w);
        longint unsigned ea[4], eb[4], fc[4], acc[8];
        longint unsigned lead;
        t_elem res;
        int n;
        n = int'(shadow_deg);
        if (n < 1) n = 1;
        if (n > 4) n = 4;
        for (int i = 0; i < 8; i++) acc[i] = 0;
        for (int i = 0; i < 4; i++) begin
            ea[i] = (i < n) ? fold(w.a[i]) : 0;
            eb[i] = (i < n) ? fold(w.b[i]) : 0;
            fc[i] = (i < n) ? fold(shadow_poly[i]) : 0;
        end
        if (w.op == OP_ADD) begin
            for (int i = 0; i < n; i++) acc[i] = (ea[i] + eb[i]) % FIELD;
        end else begin
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    acc[i+j] = (acc[i+j] + (ea[i] * eb[j]) % FIELD) % FIELD;
            // fold high terms down: x^n = -(lower part of f)
            for (int k = 2 * n - 2; k >= n; k--) begin
                lead = acc[k];
                acc[k] = 0;
                for (int i = 0; i < n; i++)
                    acc[k-n+i] = (acc[k-n+i] + FIELD - (lead * fc[i]) % FIELD) % FIELD;
            end
        end
        for (int i = 0; i < 4; i++) res[i] = (i < n) ? t_coef'(acc[i]) : '0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input t_coef got, input t_coef want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    // driver: presents pending words at the falling edge, with random gaps unless quiet
    always @(negedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && accepted_cnt < issued_cnt) begin
            // word still on the port, hold it
        end else if (idle_left > 0) begin
            start <= 1'b0;
            idle_left <= idle_left - 1;
        end else if (!quiet && pending_words.size() > 0 && $urandom_range(0, 7) == 0) begin
            start <= 1'b0;
            idle_left <= $urandom_range(0, 8);
        end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            start      <= 1'b1;
            i_opcode   <= w.op;
            i_a_coef_0 <= w.a[0];
            i_a_coef_1 <= w.a[1];
            i_a_coef_2 <= w.a[2];
            i_a_coef_3 <= w.a[3];
            i_b_coef_0 <= w.b[0];
            i_b_coef_1 <= w.b[1];
            i_b_coef_2 <= w.b[2];
            i_b_coef_3 <= w.b[3];
            issued_cnt <= issued_cnt + 1;
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: captures accepted words and checks strobed results
    always @(posedge i_clk) begin
        t_word w;
        t_elem want;
        t_elem got;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout");
            $display("DONE: errors detected");
            $finish;
        end
        if (i_rst_n && start && !busy) begin
            w.op = i_opcode;
            w.a = {i_a_coef_3, i_a_coef_2, i_a_coef_1, i_a_coef_0};
            w.b = {i_b_coef_3, i_b_coef_2, i_b_coef_1, i_b_coef_0};
            expected_elems.push_back(field_op(w));
            accepted_cnt = accepted_cnt + 1;
        end
        if (i_rst_n && o_valid) begin
            got = {o_r_coef_3, o_r_coef_2, o_r_coef_1, o_r_coef_0};
            if (expected_elems.size() == 0) begin
                $display("unexpected result word at cycle %0d", cycle_cnt);
                err_cnt++;
            end else begin
                want = expected_elems.pop_front();
                for (int i = 0; i < 4; i++)
                    if (got[i] !== want[i])
                        report_mismatch($sformatf("r_coef_%0d", i), got[i], want[i]);
            end
        end
    end

    // coefficient mix: edges, values above p, small and full random
    function automatic t_coef rand_coef();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return t_coef'(FIELD - 1);
            2: return t_coef'($urandom_range(998244353, 30'h3fffffff));
            3: return t_coef'($urandom_range(0, 15));
            default: return t_coef'($urandom);
        endcase
    endfunction

    function automatic t_word rand_word();
        t_word w;
        w.op = 1'($urandom_range(0, 1));
        for (int i = 0; i < 4; i++) begin
            w.a[i] = rand_coef();
            w.b[i] = rand_coef();
        end
        return w;
    endfunction

    task automatic push_fill(input logic op, input t_coef av, input t_coef bv);
        t_word w;
        w.op = op;
        for (int i = 0; i < 4; i++) begin
            w.a[i] = av;
            w.b[i] = bv;
        end
        pending_words.push_back(w);
    endtask

    // sender waits here until every expected result has come out
    task automatic drain();
        while (pending_words.size() > 0 || accepted_cnt < issued_cnt || start
               || expected_elems.size() > 0)
            @(posedge i_clk);
        repeat (RESULT_LAT + 10) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [29:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_DEGREE) shadow_deg = data[2:0];
        else if (idx <= CFG_COEF_3) shadow_poly[idx - 1] = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic cfg_all(input logic [2:0] deg, input logic [29:0] c0, input logic [29:0] c1,
                           input logic [29:0] c2, input logic [29:0] c3);
        cfg_write(CFG_DEGREE, {27'd0, deg});
        cfg_write(CFG_COEF_0, c0);
        cfg_write(CFG_COEF_1, c1);
        cfg_write(CFG_COEF_2, c2);
        cfg_write(CFG_COEF_3, c3);
    endtask

    initial begin
        logic [29:0] pmax;
        logic [2:0] deg_list [10];
        pmax = 30'd998244352;
        deg_list = '{3'd4, 3'd1, 3'd0, 3'd3, 3'd7, 3'd2, 3'd5, 3'd4, 3'd6, 3'd4};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        quiet = 0;
        shadow_deg = 3'd2;
        shadow_poly = {30'd0, 30'd0, 30'd1, 30'd1};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words under the reset configuration
        for (int op = 0; op < 2; op++) begin
            push_fill(1'(op), '0, '0);
            push_fill(1'(op), pmax, pmax);
            push_fill(1'(op), pmax, 30'd1);
            push_fill(1'(op), 30'd998244353, 30'h3fffffff);
            push_fill(1'(op), 30'h3fffffff, 30'h3fffffff);
        end
        drain();

        // full degree, polynomial with extreme coefficients and values above p
        cfg_all(3'd4, pmax, 30'h3fffffff, 30'd998244353, 30'd0);
        for (int op = 0; op < 2; op++) begin
            push_fill(1'(op), pmax, pmax);
            push_fill(1'(op), 30'h3fffffff, 30'd2);
            push_fill(1'(op), 30'd1, 30'd998244353);
        end
        // writes beyond the register list must be ignored
        drain();
        cfg_write(3'd5, 30'h3fffffff);
        cfg_write(3'd6, 30'h2aaaaaaa);
        cfg_write(3'd7, 30'h15555555);
        for (int op = 0; op < 2; op++) push_fill(1'(op), pmax, 30'd3);
        drain();

        // random phases over many configurations
        for (int ph = 0; ph < 10; ph++) begin
            cfg_all(deg_list[ph],
                    (ph == 0) ? pmax : 30'($urandom),
                    (ph == 1) ? 30'd0 : 30'($urandom),
                    (ph == 2) ? pmax : 30'($urandom),
                    (ph == 3) ? 30'h3fffffff : 30'($urandom));
            if (ph == 9) quiet = 1;
            for (int k = 0; k < 172; k++) pending_words.push_back(rand_word());
            drain();
        end

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
